// ===== sv/skgc_pkg.sv =====
package skgc_pkg;

  // Number formats.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ONE        = 1 << FRAC_BITS;

  // Register widths.
  localparam int RATIO_W = 16;
  localparam int KNEE_W  = 14;
  localparam int H_W     = KNEE_W - 1;
  localparam int IDX_W   = 2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_RATIO     = 2'd1;
  localparam logic [IDX_W-1:0] REG_GATE      = 2'd2;
  localparam logic [IDX_W-1:0] REG_KNEE      = 2'd3;

  // Derived coefficient widths.
  localparam int O_W   = H_W + FRAC_BITS;
  localparam int D_W   = O_W + 1;
  localparam int C_W   = O_W + 1;
  localparam int HXO_W = H_W + O_W;

  // Datapath widths.
  localparam int X_W  = DATA_WIDTH + 1;
  localparam int P_W  = X_W + 1 + D_W;
  localparam int A_W  = HXO_W + 2;
  localparam int R_W  = A_W / 2;
  localparam int N_W  = O_W + FRAC_BITS + 1;
  localparam int DV_W = D_W;
  localparam int T_W  = FRAC_BITS + 3;
  localparam int TT_W = 2 * T_W;
  localparam int T2_W = TT_W - FRAC_BITS;
  localparam int HT_W = H_W + 1 + T_W;
  localparam int CT_W = C_W + T2_W + 1;
  localparam int Y_W  = P_W;

  // Reset values and the coefficients that follow from them.
  localparam int THR_RST   = 0;
  localparam int RATIO_RST = 1024;
  localparam int GATE_RST  = 256;
  localparam int KNEE_RST  = 1536;
  localparam int H_RST     = KNEE_RST / 2;
  localparam int O_RST     = (H_RST * ONE) / GATE_RST;
  localparam int C_RST     = (H_RST * ONE) / RATIO_RST - H_RST;
  localparam int D_RST     = (GATE_RST == ONE) ? 0 : H_RST - O_RST;
  localparam longint HXO_RST = longint'(H_RST) * longint'(O_RST);

  // Region of the transfer curve that a request falls in.
  typedef enum logic [1:0] {
    K_ABOVE,
    K_BELOW,
    K_LIN,
    K_ROOT
  } kind_t;

  // Configuration and derived coefficients.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] thr;
    logic [RATIO_W-1:0]           r;
    logic [RATIO_W-1:0]           g;
    logic [KNEE_W-1:0]            knee;
    logic [H_W-1:0]               h;
    logic [O_W-1:0]               o;
    logic signed [D_W-1:0]        d;
    logic signed [C_W-1:0]        c;
    logic [HXO_W-1:0]             hxo;
    logic                         use_lin;
  } cfg_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    kind_t                 kind;
    logic signed [X_W-1:0] x;
  } fe_item_t;

  localparam int FE_W = $bits(fe_item_t);

endpackage

// ===== sv/skgc_fifo.sv =====
module skgc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Storage; pointers wrap since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("queue count beyond its depth");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wptr == rptr))
    else $error("queue pointers disagree with the count");

endmodule

// ===== sv/skgc_regs.sv =====
module skgc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [skgc_pkg::IDX_W-1:0]          cfg_idx,
  input  logic [skgc_pkg::DATA_WIDTH-1:0]     cfg_data,
  output skgc_pkg::cfg_t                      cfg,
  output logic                                busy
);

  localparam int DW  = skgc_pkg::DATA_WIDTH;
  localparam int F   = skgc_pkg::FRAC_BITS;
  localparam int RW  = skgc_pkg::RATIO_W;
  localparam int QW  = skgc_pkg::O_W;
  localparam int CNW = $clog2(QW);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_DIVO = 5'b00100,
    ST_DIVC = 5'b01000,
    ST_MUL  = 5'b10000
  } state_t;

  state_t                          state;
  logic [DW-1:0]                   thr;
  logic [RW-1:0]                   ratio;
  logic [RW-1:0]                   gate;
  logic [skgc_pkg::KNEE_W-1:0]     knee;
  logic [skgc_pkg::O_W-1:0]        o;
  logic signed [skgc_pkg::D_W-1:0] d;
  logic signed [skgc_pkg::C_W-1:0] c;
  logic [skgc_pkg::HXO_W-1:0]      hxo;
  logic [CNW-1:0]                  cnt;
  logic [QW-1:0]                   quo;
  logic [RW-1:0]                   rem;

  logic [skgc_pkg::H_W-1:0] h;
  logic [RW-1:0]            r_eff;
  logic [RW-1:0]            g_eff;
  logic [RW-1:0]            dvs;
  logic [RW:0]              sh;
  logic                     ge;
  logic [RW-1:0]            rem_next;
  logic [QW-1:0]            quo_next;
  logic                     done;

  // A ratio or gate of zero counts as the smallest step.
  assign h     = knee[skgc_pkg::KNEE_W-1:1];
  assign r_eff = (ratio == '0) ? RW'(1) : ratio;
  assign g_eff = (gate == '0) ? RW'(1) : gate;

  // One quotient bit per cycle of the coefficient divider.
  assign dvs      = (state == ST_DIVO) ? g_eff : r_eff;
  assign sh       = {rem, quo[QW-1]};
  assign ge       = (sh >= {1'b0, dvs});
  assign rem_next = ge ? RW'(sh - {1'b0, dvs}) : sh[RW-1:0];
  assign quo_next = {quo[QW-2:0], ge};
  assign done     = (cnt == CNW'(QW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      thr   <= DW'(skgc_pkg::THR_RST);
      ratio <= RW'(skgc_pkg::RATIO_RST);
      gate  <= RW'(skgc_pkg::GATE_RST);
      knee  <= skgc_pkg::KNEE_W'(skgc_pkg::KNEE_RST);
      o     <= skgc_pkg::O_W'(skgc_pkg::O_RST);
      d     <= skgc_pkg::D_W'(skgc_pkg::D_RST);
      c     <= skgc_pkg::C_W'(skgc_pkg::C_RST);
      hxo   <= skgc_pkg::HXO_W'(skgc_pkg::HXO_RST);
      cnt   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        skgc_pkg::REG_THRESHOLD: thr   <= cfg_data;
        skgc_pkg::REG_RATIO:     ratio <= cfg_data[RW-1:0];
        skgc_pkg::REG_GATE:      gate  <= cfg_data[RW-1:0];
        skgc_pkg::REG_KNEE:      knee  <= cfg_data[skgc_pkg::KNEE_W-1:0];
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_IDLE: ;
        ST_LOAD: begin
          quo   <= {h, F'(0)};
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIVO;
        end
        ST_DIVO: begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt + CNW'(1);
          if (done) begin
            o     <= quo_next;
            quo   <= {h, F'(0)};
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIVC;
          end
        end
        ST_DIVC: begin
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt + CNW'(1);
          if (done) begin
            c     <= $signed({1'b0, quo_next}) - $signed(skgc_pkg::C_W'(h));
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          hxo <= skgc_pkg::HXO_W'(h) * skgc_pkg::HXO_W'(o);
          if (g_eff == RW'(skgc_pkg::ONE)) begin
            d <= '0;
          end else begin
            d <= $signed(skgc_pkg::D_W'(h)) - $signed({1'b0, o});
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cfg         = '0;
    cfg.thr     = $signed(thr);
    cfg.r       = r_eff;
    cfg.g       = g_eff;
    cfg.knee    = knee;
    cfg.h       = h;
    cfg.o       = o;
    cfg.d       = d;
    cfg.c       = c;
    cfg.hxo     = hxo;
    cfg.use_lin = (d == '0);
  end

  a_write_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("coefficient update did not start after a write");
  a_mul_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state == ST_MUL) && !$past(cfg_we)) |-> !busy)
    else $error("coefficient update did not finish after the product");

endmodule

// ===== sv/skgc_front.sv =====
module skgc_front (
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [skgc_pkg::DATA_WIDTH-1:0] level_db,
  input  skgc_pkg::cfg_t                       cfg,
  input  logic                                 busy,
  input  logic                                 q_full,
  output logic                                 q_push,
  output skgc_pkg::fe_item_t                   q_item
);

  localparam int XW = skgc_pkg::X_W;
  localparam int CW = XW + 2;

  logic signed [XW-1:0] x;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] kn;
  logic                 in_knee;

  // Level relative to threshold; the knee test compares 2x against the full width.
  assign x       = XW'(level_db) - XW'(cfg.thr);
  assign x2      = $signed({x[XW-1], x, 1'b0});
  assign kn      = $signed(CW'(cfg.knee));
  assign in_knee = (x2 > -kn) && (x2 < kn);

  assign full   = q_full || busy;
  assign q_push = push && !full;

  // Classify the request by region of the curve.
  always_comb begin
    q_item   = '0;
    q_item.x = x;
    if (in_knee) begin
      q_item.kind = cfg.use_lin ? skgc_pkg::K_LIN : skgc_pkg::K_ROOT;
    end else if (!x[XW-1] && (x != '0)) begin
      q_item.kind = skgc_pkg::K_ABOVE;
    end else begin
      q_item.kind = skgc_pkg::K_BELOW;
    end
  end

endmodule

// ===== sv/skgc_back.sv =====
module skgc_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  skgc_pkg::cfg_t                         cfg,
  input  logic                                   in_empty,
  input  skgc_pkg::fe_item_t                     in_item,
  output logic                                   in_pop,
  input  logic                                   out_full,
  output logic                                   out_push,
  output logic signed [skgc_pkg::DATA_WIDTH-1:0] out_gain,
  output logic                                   out_sat
);

  localparam int F    = skgc_pkg::FRAC_BITS;
  localparam int DW   = skgc_pkg::DATA_WIDTH;
  localparam int XW   = skgc_pkg::X_W;
  localparam int PW   = skgc_pkg::P_W;
  localparam int AW   = skgc_pkg::A_W;
  localparam int RW   = skgc_pkg::R_W;
  localparam int NW   = skgc_pkg::N_W;
  localparam int DVW  = skgc_pkg::DV_W;
  localparam int DCW  = skgc_pkg::D_W;
  localparam int OW   = skgc_pkg::O_W;
  localparam int TW   = skgc_pkg::T_W;
  localparam int TTW  = skgc_pkg::TT_W;
  localparam int T2W  = skgc_pkg::T2_W;
  localparam int HTW  = skgc_pkg::HT_W;
  localparam int CTW  = skgc_pkg::CT_W;
  localparam int YW   = skgc_pkg::Y_W;
  localparam int HW   = skgc_pkg::H_W;

  // Stage positions.
  localparam int S_MUL = 0;
  localparam int S_ARG = 1;
  localparam int S_SQ0 = 2;
  localparam int S_SEL = S_SQ0 + RW;
  localparam int S_DV0 = S_SEL + 1;
  localparam int S_QT  = S_DV0 + NW;
  localparam int S_TT  = S_QT + 1;
  localparam int S_HT  = S_TT + 1;
  localparam int S_CT  = S_HT + 1;
  localparam int S_OUT = S_CT + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic signed [NW:0]   Q_TMAX = (NW + 1)'(2 * skgc_pkg::ONE);
  localparam logic signed [YW-1:0] Y_HI   = YW'((64'sd1 <<< (DW - 1)) - 1);
  localparam logic signed [YW-1:0] Y_LO   = -YW'(64'sd1 <<< (DW - 1));

  typedef struct packed {
    skgc_pkg::kind_t         kind;
    logic signed [XW-1:0]    x;
    logic signed [PW-1:0]    prod;
    logic [AW-1:0]           arg;
    logic [RW+1:0]           srem;
    logic [RW-1:0]           root;
    logic [NW-1:0]           num;
    logic [DVW-1:0]          drem;
    logic [DVW-1:0]          den;
    logic                    neg;
    logic signed [TW-1:0]    t;
    logic [TTW-1:0]          tt;
    logic signed [HTW-1:0]   ht;
    logic signed [CTW-1:0]   ct;
    logic signed [YW-1:0]    y;
    logic                    sat;
  } stage_t;

  stage_t pipe [NST];
  stage_t nxt  [NST];
  logic   vld  [NST];
  logic   adv;
  logic   is_knee [NST];

  // The whole pipeline moves while the result queue has room.
  assign adv      = !out_full;
  assign in_pop   = adv && !in_empty;
  assign out_push = adv && vld[S_OUT];
  assign out_gain = pipe[S_OUT].y[DW-1:0];
  assign out_sat  = pipe[S_OUT].sat;

  for (genvar k = 0; k < NST; k++) begin : g_kind
    assign is_knee[k] = (pipe[k].kind == skgc_pkg::K_LIN) || (pipe[k].kind == skgc_pkg::K_ROOT);
  end

  // One shared multiplier: x*d for the root argument, or -x*(1-gate) below threshold.
  always_comb begin
    logic signed [XW:0]     ma;
    logic signed [DCW-1:0]  mb;
    logic signed [RW-1:0]   unused_pad;
    unused_pad = '0;
    if (in_item.kind == skgc_pkg::K_BELOW) begin
      ma = -(XW + 1)'(in_item.x);
      mb = DCW'($signed({1'b0, 16'(skgc_pkg::ONE)}) - $signed({1'b0, cfg.g}));
    end else begin
      ma = (XW + 1)'(in_item.x);
      mb = cfg.d;
    end
    nxt[S_MUL]      = '0;
    nxt[S_MUL].kind = in_item.kind;
    nxt[S_MUL].x    = in_item.x;
    nxt[S_MUL].prod = PW'(ma * mb) + PW'(unused_pad);
  end

  // Root argument h*o + x*d, clamped at zero.
  always_comb begin
    logic signed [PW:0] sum;
    sum = $signed({1'b0, PW'(cfg.hxo)}) + (PW + 1)'(pipe[S_ARG - 1].prod);
    nxt[S_ARG]      = pipe[S_ARG - 1];
    nxt[S_ARG].arg  = sum[PW] ? '0 : sum[AW-1:0];
    nxt[S_ARG].srem = '0;
    nxt[S_ARG].root = '0;
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    always_comb begin
      logic [RW+3:0] rem4;
      logic [RW+3:0] trial;
      logic          ge;
      rem4  = {pipe[S_SQ0 + j - 1].srem, pipe[S_SQ0 + j - 1].arg[AW-1 -: 2]};
      trial = (RW + 4)'({pipe[S_SQ0 + j - 1].root, 2'b01});
      ge    = (rem4 >= trial);
      nxt[S_SQ0 + j]      = pipe[S_SQ0 + j - 1];
      nxt[S_SQ0 + j].srem = ge ? (RW + 2)'(rem4 - trial) : rem4[RW+1:0];
      nxt[S_SQ0 + j].root = {pipe[S_SQ0 + j - 1].root[RW-2:0], ge};
      nxt[S_SQ0 + j].arg  = pipe[S_SQ0 + j - 1].arg << 2;
    end
  end

  // Pick the single division of this request and split it into sign and magnitudes.
  always_comb begin
    stage_t               p;
    logic signed [OW+1:0] sn;
    logic signed [XW:0]   xh;
    logic signed [NW:0]   nsig;
    logic signed [DCW-1:0] dsig;
    logic [NW:0]          nabs;
    logic [DCW-1:0]       dabs;
    p    = pipe[S_SEL - 1];
    sn   = $signed((OW + 2)'(p.root)) - $signed((OW + 2)'(cfg.o));
    xh   = (XW + 1)'(p.x) + $signed((XW + 1)'(cfg.h));
    case (p.kind)
      skgc_pkg::K_ROOT: begin
        nsig = (NW + 1)'({sn, F'(0)});
        dsig = cfg.d;
      end
      skgc_pkg::K_LIN: begin
        nsig = (NW + 1)'(xh) <<< F;
        dsig = $signed(DCW'(cfg.knee));
      end
      default: begin
        nsig = (NW + 1)'(p.x) <<< F;
        dsig = $signed(DCW'(cfg.r));
      end
    endcase
    nabs = nsig[NW] ? NW'(-nsig) : nsig[NW-1:0];
    dabs = dsig[DCW-1] ? DCW'(-dsig) : dsig;
    nxt[S_SEL]      = p;
    nxt[S_SEL].num  = nabs[NW-1:0];
    nxt[S_SEL].den  = dabs;
    nxt[S_SEL].drem = '0;
    nxt[S_SEL].neg  = nsig[NW] ^ dsig[DCW-1];
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 0; j < NW; j++) begin : g_div
    always_comb begin
      logic [DVW:0] sh;
      logic         ge;
      sh = {pipe[S_DV0 + j - 1].drem, pipe[S_DV0 + j - 1].num[NW-1]};
      ge = (sh >= {1'b0, pipe[S_DV0 + j - 1].den});
      nxt[S_DV0 + j]      = pipe[S_DV0 + j - 1];
      nxt[S_DV0 + j].drem = ge ? DVW'(sh - {1'b0, pipe[S_DV0 + j - 1].den}) : sh[DVW-1:0];
      nxt[S_DV0 + j].num  = {pipe[S_DV0 + j - 1].num[NW-2:0], ge};
    end
  end

  // Signed quotient: curve parameter t, clamped to +-2.0, or the gain above threshold.
  always_comb begin
    logic signed [NW:0] q;
    logic signed [NW:0] qs;
    q  = $signed({1'b0, pipe[S_QT - 1].num});
    qs = pipe[S_QT - 1].neg ? -q : q;
    nxt[S_QT]   = pipe[S_QT - 1];
    nxt[S_QT].y = YW'(qs) - YW'(pipe[S_QT - 1].x);
    if (qs > Q_TMAX) begin
      nxt[S_QT].t = TW'(Q_TMAX);
    end else if (qs < -Q_TMAX) begin
      nxt[S_QT].t = TW'(-Q_TMAX);
    end else begin
      nxt[S_QT].t = qs[TW-1:0];
    end
  end

  // t squared.
  always_comb begin
    logic signed [TTW-1:0] sq;
    sq = pipe[S_TT - 1].t * pipe[S_TT - 1].t;
    nxt[S_TT]    = pipe[S_TT - 1];
    nxt[S_TT].tt = sq;
  end

  // h times t.
  always_comb begin
    nxt[S_HT]    = pipe[S_HT - 1];
    nxt[S_HT].ht = $signed({1'b0, cfg.h}) * pipe[S_HT - 1].t;
  end

  // Curvature term c times floor(t*t).
  always_comb begin
    logic [T2W-1:0] t2;
    t2 = T2W'(pipe[S_CT - 1].tt >> F);
    nxt[S_CT]    = pipe[S_CT - 1];
    nxt[S_CT].ct = cfg.c * $signed({1'b0, t2});
  end

  // Gain of the request's region, then saturation.
  always_comb begin
    stage_t             p;
    logic signed [YW-1:0] yk;
    logic signed [YW-1:0] yr;
    p  = pipe[S_OUT - 1];
    yk = YW'(p.ht >>> (F - 1)) - $signed(YW'({1'b0, cfg.h})) - YW'(p.x) + YW'(p.ct >>> F);
    if (is_knee[S_OUT - 1]) begin
      yr = yk;
    end else if (p.kind == skgc_pkg::K_ABOVE) begin
      yr = p.y;
    end else begin
      yr = YW'(p.prod >>> F);
    end
    nxt[S_OUT] = p;
    if (yr > Y_HI) begin
      nxt[S_OUT].y   = Y_HI;
      nxt[S_OUT].sat = 1'b1;
    end else if (yr < Y_LO) begin
      nxt[S_OUT].y   = Y_LO;
      nxt[S_OUT].sat = 1'b1;
    end else begin
      nxt[S_OUT].y   = yr;
      nxt[S_OUT].sat = 1'b0;
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= !in_empty;
      for (int k = 1; k < NST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("result pushed while the result queue is full");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(out_full) && !$past(rst)) |-> (vld[S_OUT] == $past(vld[S_OUT])))
    else $error("pipeline moved during a stall");
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    (vld[S_OUT] && pipe[S_OUT].sat) |-> ((pipe[S_OUT].y == Y_HI) || (pipe[S_OUT].y == Y_LO)))
    else $error("saturated result is not at a range limit");

endmodule

// ===== sv/soft_knee_gain_computer.sv =====
// Soft-knee gain computer: each request is a level in dB (signed Q8.8) and yields
// one gain change in dB with a saturation flag, in request order. With steady pops
// the block takes one request per clock; a request passes the mid queue and the back
// pipeline, with its 18-stage square root and 30-stage divider, before it reaches the
// result queue. After every configuration write the block holds full high while a
// bit-serial divider recomputes the knee coefficients; right after reset no such
// wait is needed.
module soft_knee_gain_computer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [skgc_pkg::DATA_WIDTH-1:0] level_db,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [skgc_pkg::DATA_WIDTH-1:0] gain_db,
  output logic                                   saturated,
  input  logic                                   cfg_we,
  input  logic [skgc_pkg::IDX_W-1:0]             cfg_idx,
  input  logic [skgc_pkg::DATA_WIDTH-1:0]        cfg_data
);

  localparam int OUT_W = skgc_pkg::DATA_WIDTH + 1;

  skgc_pkg::cfg_t     cfg;
  logic               busy;
  logic               q_full;
  logic               q_push;
  skgc_pkg::fe_item_t q_item;
  logic               q_empty;
  logic               q_pop;
  logic [skgc_pkg::FE_W-1:0] q_rdata;
  logic               o_full;
  logic               o_push;
  logic signed [skgc_pkg::DATA_WIDTH-1:0] o_gain;
  logic               o_sat;
  logic [OUT_W-1:0]   o_rdata;

  skgc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .busy     (busy)
  );

  skgc_front u_front (
    .push     (push),
    .full     (full),
    .level_db (level_db),
    .cfg      (cfg),
    .busy     (busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // Queue between classification and the arithmetic pipeline.
  skgc_fifo #(
    .WIDTH (skgc_pkg::FE_W),
    .DEPTH (4)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  skgc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (q_empty),
    .in_item  (skgc_pkg::fe_item_t'(q_rdata)),
    .in_pop   (q_pop),
    .out_full (o_full),
    .out_push (o_push),
    .out_gain (o_gain),
    .out_sat  (o_sat)
  );

  // Result queue toward the consumer.
  skgc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata ({o_sat, o_gain}),
    .full  (o_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty)
  );

  assign gain_db   = $signed(o_rdata[skgc_pkg::DATA_WIDTH-1:0]);
  assign saturated = o_rdata[OUT_W-1];

endmodule

// ===== tb/soft_knee_gain_checker.sv =====
module soft_knee_gain_checker
  import skgc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic signed [DATA_WIDTH-1:0] level_db,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [DATA_WIDTH-1:0] gain_db,
  input  logic                         saturated,
  input  logic                         cfg_we,
  input  logic [IDX_W-1:0]             cfg_idx,
  input  logic [DATA_WIDTH-1:0]        cfg_data,
  output int                           fail_count,
  output int                           pending
);

  typedef struct {
    logic signed [DATA_WIDTH-1:0] gain;
    logic                         sat;
  } gain_t;

  // Shadow copy of the configuration.
  logic [DATA_WIDTH-1:0] thr_q;
  logic [RATIO_W-1:0]    ratio_q;
  logic [RATIO_W-1:0]    gate_q;
  logic [KNEE_W-1:0]     knee_q;

  gain_t gain_fifo[$];

  assign pending = gain_fifo.size();

  function automatic longint floor_shr(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return ~((~v) >>> FRAC_BITS);
  endfunction

  function automatic longint floor_root(longint a);
    longint res;
    longint bitv;
    res = 0;
    bitv = longint'(1) <<< 62;
    while (bitv > a) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a = a - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Gain curve for one level under the current settings.
  function automatic gain_t compute_gain(logic signed [DATA_WIDTH-1:0] lvl);
    gain_t  res;
    longint x, h, r, g, knee, t, o, d, arg, s, c, t2, y;
    r = (ratio_q == 0) ? 1 : longint'(ratio_q);
    g = (gate_q == 0) ? 1 : longint'(gate_q);
    knee = longint'(knee_q);
    x = longint'(lvl) - longint'($signed(thr_q));
    h = knee >>> 1;
    if (2 * x > -knee && 2 * x < knee) begin
      o = 0;
      d = 0;
      if (g != ONE) begin
        o = (h * ONE) / g;
        d = h - o;
      end
      if (d == 0) begin
        t = ((x + h) * ONE) / knee;
      end else begin
        arg = h * o + x * d;
        if (arg < 0) arg = 0;
        s = floor_root(arg);
        t = ((s - o) * ONE) / d;
      end
      if (t > 2 * ONE) t = 2 * ONE;
      if (t < -2 * ONE) t = -2 * ONE;
      c = (h * ONE) / r - h;
      t2 = (t * t) >>> FRAC_BITS;
      y = floor_shr(2 * h * t) - h - x + floor_shr(c * t2);
    end else if (x > 0) begin
      y = (x * ONE) / r - x;
    end else begin
      y = floor_shr(-x * (ONE - g));
    end
    res.sat = 1'b0;
    if (y > 32767) begin
      y = 32767;
      res.sat = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.sat = 1'b1;
    end
    res.gain = y[DATA_WIDTH-1:0];
    return res;
  endfunction

  // Track configuration writes, predict on each request, compare on each result.
  always @(posedge clk) begin
    gain_t want;
    int    errs;
    errs = 0;
    if (rst) begin
      thr_q <= DATA_WIDTH'(THR_RST);
      ratio_q <= RATIO_W'(RATIO_RST);
      gate_q <= RATIO_W'(GATE_RST);
      knee_q <= KNEE_W'(KNEE_RST);
      fail_count <= 0;
    end else begin
      if (push && !full) gain_fifo.push_back(compute_gain(level_db));
      if (pop && !empty) begin
        if (gain_fifo.size() == 0) begin
          $error("unexpected result gain_db=%0d", gain_db);
          errs = errs + 1;
        end else begin
          want = gain_fifo.pop_front();
          if (gain_db !== want.gain) begin
            $error("gain_db: expected %0d, actual %0d", want.gain, gain_db);
            errs = errs + 1;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0d, actual %0d", want.sat, saturated);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cfg_we) begin
        case (cfg_idx)
          REG_THRESHOLD: thr_q <= cfg_data;
          REG_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
          REG_GATE: gate_q <= cfg_data[RATIO_W-1:0];
          REG_KNEE: knee_q <= cfg_data[KNEE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/soft_knee_gain_computer_tb.sv =====
module soft_knee_gain_computer_tb;
  import skgc_pkg::*;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         push = 1'b0;
  logic                         full;
  logic signed [DATA_WIDTH-1:0] level_db = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic signed [DATA_WIDTH-1:0] gain_db;
  logic                         saturated;
  logic                         cfg_we = 1'b0;
  logic [IDX_W-1:0]             cfg_idx = '0;
  logic [DATA_WIDTH-1:0]        cfg_data = '0;
  int                           fail_count;
  int                           pending;
  int                           cycle_count = 0;
  int                           send_idle = 0;
  int                           recv_idle = 0;
  logic signed [DATA_WIDTH-1:0] thr_now = '0;

  localparam int CYCLE_LIMIT = 400000;

  always #5 clk = ~clk;

  soft_knee_gain_computer u_top (.*);

  soft_knee_gain_checker u_check (.*);

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("soft_knee_gain_computer_tb: done, errors");
      $finish;
    end
  end

  // Result side: pop with a random stall rate.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // Send one request, holding it until it is accepted. Push stays high after
  // acceptance so that requests can follow back to back.
  task automatic send_level(input logic signed [DATA_WIDTH-1:0] lvl);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    level_db <= lvl;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Let the block drain before touching a register.
  task automatic drain;
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) thr_now = val;
    repeat (50) @(posedge clk);
  endtask

  // Mostly levels near the threshold so the knee gets heavy traffic.
  function automatic logic [DATA_WIDTH-1:0] pick_level();
    int k;
    k = $urandom_range(9);
    if (k < 5) return thr_now + $signed(16'($urandom_range(4000))) - 16'sd2000;
    if (k < 7) return thr_now + $signed(16'($urandom_range(400))) - 16'sd200;
    return 16'($urandom);
  endfunction

  initial begin
    logic signed [DATA_WIDTH-1:0] edges[10];
    edges = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd767, -16'sd767,
              16'sd768, -16'sd768, 16'sd3000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes at reset settings.
    foreach (edges[i]) send_level(edges[i]);
    drain();
    // Hard knee, zero ratio and gate, max knee and ratio, extreme threshold.
    write_reg(REG_KNEE, 16'd0);
    write_reg(REG_RATIO, 16'd0);
    write_reg(REG_GATE, 16'd0);
    foreach (edges[i]) send_level(edges[i]);
    drain();
    write_reg(REG_KNEE, 16'hFFFF);
    write_reg(REG_RATIO, 16'hFFFF);
    write_reg(REG_GATE, 16'd300);
    write_reg(REG_THRESHOLD, 16'h8000);
    foreach (edges[i]) send_level(edges[i]);
    drain();

    // Random phases, each with fresh settings and an idling pattern.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 45; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 45; end
        default: begin send_idle = 9; recv_idle = 9; end
      endcase
      write_reg(REG_THRESHOLD, (ph == 5) ? 16'h7FFF : 16'($urandom));
      write_reg(REG_RATIO, (ph == 6) ? 16'd256 : 16'($urandom_range(65535)));
      case ($urandom_range(3))
        0: write_reg(REG_GATE, 16'd256);
        1: write_reg(REG_GATE, 16'($urandom_range(250, 262)));
        default: write_reg(REG_GATE, 16'($urandom));
      endcase
      write_reg(REG_KNEE, (ph == 7) ? 16'd12800 : 16'($urandom_range(12800)));
      if (ph == 8) write_reg(REG_KNEE, 16'($urandom) | 16'hC000);
      repeat (88) send_level(pick_level());
      drain();
    end

    if (fail_count == 0) begin
      $display("soft_knee_gain_computer_tb: done, clean");
    end else begin
      $display("soft_knee_gain_computer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/skgc_pkg.sv
sv/skgc_fifo.sv
sv/skgc_regs.sv
sv/skgc_front.sv
sv/skgc_back.sv
sv/soft_knee_gain_computer.sv
tb/soft_knee_gain_checker.sv
tb/soft_knee_gain_computer_tb.sv
